[rtl/fsi_pkg.sv]
// Shared types, constants and saturation helpers for the fish swarm iteration block.
package fsi_pkg;

    localparam int FISH_COUNT_DEF = 64;

    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 6;
    localparam int POS_W      = 24;
    localparam int MASS_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider operand widths: gain (16 bits) times a 25-bit difference, over mass * 256
    localparam int NUM_W = 41;
    localparam int DEN_W = 40;

    localparam int CURVE_WEIGHT = 100;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
    localparam logic [MASS_W-1:0]       MASS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_NOISE = 2'd1,
        KIND_STEP  = 2'd2
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SOCIAL_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHOOL_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_KEEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FLOOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HIGH    = 3'd6;

    localparam logic [15:0]             SOCIAL_GAIN_RST   = 16'd6554;
    localparam logic [22:0]             SCHOOL_RADIUS_RST = 23'd131072;
    localparam logic [15:0]             VELOCITY_KEEP_RST = 16'd62259;
    localparam logic [15:0]             WEIGHT_GAIN_RST   = 16'd655;
    localparam logic [MASS_W-1:0]       WEIGHT_FLOOR_RST  = 32'd256;
    localparam logic signed [POS_W-1:0] BOUND_LOW_RST     = -24'sd327680;
    localparam logic signed [POS_W-1:0] BOUND_HIGH_RST    = 24'sd655360;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic [MASS_W-1:0]       mass;
        logic [MASS_W-1:0]       fitness;
    } fish_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } noise_t;

    // Clamp a one-bit-wider sum back into Q8.16
    function automatic logic signed [POS_W-1:0] sat_pos(input logic [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1])
            r = v[POS_W] ? POS_MIN : POS_MAX;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] add_pos(input logic signed [POS_W-1:0] a,
                                                        input logic signed [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {a[POS_W-1], a} + {b[POS_W-1], b};
        return sat_pos(s);
    endfunction

    function automatic logic signed [POS_W-1:0] neg_pos(input logic signed [POS_W-1:0] a);
        logic [POS_W:0] s;
        s = (POS_W+1)'(0) - {a[POS_W-1], a};
        return sat_pos(s);
    endfunction

endpackage

[rtl/fsi_if.sv]
// Valid/ready channel interfaces for fish items and fish results.
interface fsi_in_if;
    import fsi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [INDEX_W-1:0]        index;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   vel_x;
    logic signed [POS_W-1:0]   vel_y;
    logic [MASS_W-1:0]         mass;
    logic [MASS_W-1:0]         last_fitness;
    logic signed [POS_W-1:0]   noise_x;
    logic signed [POS_W-1:0]   noise_y;

    modport source (output valid, kind, index, pos_x, pos_y, vel_x, vel_y, mass,
                    last_fitness, noise_x, noise_y, input ready);
    modport sink   (input valid, kind, index, pos_x, pos_y, vel_x, vel_y, mass,
                    last_fitness, noise_x, noise_y, output ready);
endinterface

interface fsi_out_if;
    import fsi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [INDEX_W-1:0]        fish_index;
    logic signed [POS_W-1:0]   out_pos_x;
    logic signed [POS_W-1:0]   out_pos_y;
    logic signed [POS_W-1:0]   out_vel_x;
    logic signed [POS_W-1:0]   out_vel_y;
    logic [MASS_W-1:0]         out_mass;
    logic                      last;

    modport source (output valid, fish_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                    out_mass, last, input ready);
    modport sink   (input valid, fish_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                    out_mass, last, output ready);
endinterface

[rtl/fsi_div.sv]
// Radix-2 restoring divider for the social pull, saturating to Q8.16.
module fsi_div
    import fsi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]         den,
    output logic                     done,
    output logic signed [POS_W-1:0]  quo
);

    localparam int CNT_W = $clog2(POS_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POS_W - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [POS_W-1:0]        low_reg;
    logic                    neg_reg;
    logic                    ovf_reg;
    logic                    zero_reg;
    logic                    nz_reg;

    logic [NUM_W-1:0]        num_abs;
    logic [DEN_W:0]          rem2;
    logic                    ge;
    logic [DEN_W:0]          diff;

    assign num_abs = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
    assign rem2    = {rem_reg, low_reg[POS_W-1]};
    assign ge      = rem2 >= {1'b0, den_reg};
    assign diff    = rem2 - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Low bits shift out at the top while quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DEN_W'(num_abs[NUM_W-1:POS_W]);
            low_reg  <= num_abs[POS_W-1:0];
            den_reg  <= den;
            neg_reg  <= num[NUM_W-1];
            nz_reg   <= (num != '0);
            zero_reg <= (den == '0);
            ovf_reg  <= (DEN_W'(num_abs[NUM_W-1:POS_W]) >= den);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            low_reg <= {low_reg[POS_W-2:0], ge};
        end
    end

    always_comb
    begin
        priority if (zero_reg)
            quo = nz_reg ? (neg_reg ? POS_MIN : POS_MAX) : '0;
        else if (ovf_reg)
            quo = neg_reg ? POS_MIN : POS_MAX;
        else if (!neg_reg)
            quo = low_reg[POS_W-1] ? POS_MAX : low_reg;
        else if (low_reg > {1'b1, {(POS_W-1){1'b0}}})
            quo = POS_MIN;
        else
            quo = POS_W'(0) - low_reg;
    end

    assign done = done_reg;

endmodule

[rtl/fish_swarm_iteration_top.sv]
// Fish school search iteration engine: fish memory, pair loop and per-fish update.
//
//  channel   | dir | transaction
//  ----------+-----+-------------------------------------------------------------
//  fish_in   | in  | kind 0 loads a fish, kind 1 sets its noise, kind 2 runs a step
//  fish_out  | out | one updated fish per slot, in slot order, last on the final one
//  cfg_*     | in  | write enable, register index, data; no read-back
//
//  A step runs every pair of the N fish through one fish-memory read and one shared
//  distance path; each near pair of distinct fish waits on the two 24-step dividers,
//  and each fish ends with the update states S_MOVE and S_F1 to S_F7 and one write-back.
//  Reset is asynchronous; the noise store reads as zero until written.
//  Output stalls hold the emission loop; items are taken only while the engine is idle.
module fish_swarm_iteration_top
    import fsi_pkg::*;
#(
    parameter int FISH_COUNT = FISH_COUNT_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    fsi_in_if.sink                fish_in,
    fsi_out_if.source             fish_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(FISH_COUNT);
    localparam logic [AW-1:0] LAST_SLOT = AW'(FISH_COUNT - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RDI, S_CAPI, S_RDJ, S_DIFF, S_MUL, S_NEAR, S_DIV,
        S_MOVE, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_WB, S_ERD, S_ECAP
    } state_t;

    // configuration
    logic [15:0]             gain_reg;
    logic [22:0]             radius_reg;
    logic [15:0]             keep_reg;
    logic [15:0]             wgain_reg;
    logic [MASS_W-1:0]       wfloor_reg;
    logic signed [POS_W-1:0] blow_reg;
    logic signed [POS_W-1:0] bhigh_reg;
    logic [45:0]             r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= SOCIAL_GAIN_RST;
            radius_reg <= SCHOOL_RADIUS_RST;
            keep_reg   <= VELOCITY_KEEP_RST;
            wgain_reg  <= WEIGHT_GAIN_RST;
            wfloor_reg <= WEIGHT_FLOOR_RST;
            blow_reg   <= BOUND_LOW_RST;
            bhigh_reg  <= BOUND_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOCIAL_GAIN:   gain_reg   <= cfg_data[15:0];
                CFG_SCHOOL_RADIUS: radius_reg <= cfg_data[22:0];
                CFG_VELOCITY_KEEP: keep_reg   <= cfg_data[15:0];
                CFG_WEIGHT_GAIN:   wgain_reg  <= cfg_data[15:0];
                CFG_WEIGHT_FLOOR:  wfloor_reg <= cfg_data[MASS_W-1:0];
                CFG_BOUND_LOW:     blow_reg   <= cfg_data[POS_W-1:0];
                CFG_BOUND_HIGH:    bhigh_reg  <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= radius_reg * radius_reg;
    end

    // control
    state_t          state_reg;
    logic [AW-1:0]   i_reg;
    logic [AW-1:0]   j_reg;
    logic            out_valid_reg;

    logic            in_acc;
    logic            idx_ok;
    logic            near;
    logic            div_start;
    logic            div_done;
    logic            done_x;
    logic            done_y;
    logic            slot_free;
    logic [48:0]     dist2;

    assign fish_in.ready = (state_reg == S_IDLE);
    assign in_acc        = fish_in.valid && fish_in.ready;
    assign idx_ok        = ({1'b0, fish_in.index} < (INDEX_W+1)'(FISH_COUNT));
    assign slot_free     = !out_valid_reg || fish_out.ready;
    assign div_done      = done_x && done_y;

    // fish memory: one write port, one registered read port
    fish_t           fish_mem [FISH_COUNT];
    fish_t           fish_rd_reg;
    fish_t           fish_wdata;
    logic            fish_we;
    logic [AW-1:0]   fish_waddr;
    logic            fish_re;
    logic [AW-1:0]   fish_raddr;

    noise_t          noise_mem [FISH_COUNT];
    noise_t          noise_rd_reg;
    logic [FISH_COUNT-1:0] noise_vld_reg;
    logic            noise_hit_reg;
    logic            noise_we;
    logic            noise_re;

    // per-fish datapath
    logic signed [POS_W-1:0] pix_reg, piy_reg, vx_reg, vy_reg, nx_reg, ny_reg;
    logic [MASS_W-1:0]       mi_reg, fi_reg, mj_reg;
    logic signed [POS_W:0]   dx_reg, dy_reg;
    logic [47:0]             dx2_reg, dy2_reg;
    logic signed [NUM_W-1:0] numx_reg, numy_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, nvx_reg, nvy_reg;
    logic signed [POS_W:0]   a_reg;
    logic [46:0]             xx_reg;
    logic [47:0]             a2_reg;
    logic signed [31:0]      t16_reg;
    logic signed [40:0]      pkx_reg, pky_reg;
    logic [39:0]             t2_reg;
    logic [MASS_W-1:0]       fit_new_reg;
    logic signed [49:0]      dn_reg;
    logic signed [33:0]      delta_reg;
    logic [MASS_W-1:0]       mass_new_reg;

    logic signed [POS_W-1:0] qx, qy;

    logic signed [49:0]      dx_sq, dy_sq;
    logic signed [41:0]      num_x, num_y;
    logic signed [47:0]      px_sq;
    logic signed [49:0]      a_sq;
    logic signed [47:0]      t32, t32_b;
    logic signed [40:0]      pk_x, pk_y, pkx_b, pky_b;
    logic signed [63:0]      t_sq;
    logic [47:0]             fsum;
    logic signed [32:0]      fdiff;
    logic signed [49:0]      dn, dn_b;
    logic signed [34:0]      w;
    logic                    oob;

    assign fish_re    = (state_reg == S_RDI) || (state_reg == S_RDJ) || (state_reg == S_ERD);
    assign fish_raddr = (state_reg == S_RDJ) ? j_reg : i_reg;
    assign noise_re   = (state_reg == S_RDI);

    assign fish_we    = (state_reg == S_WB) ||
                        (in_acc && fish_in.kind == KIND_LOAD && idx_ok);
    assign fish_waddr = (state_reg == S_WB) ? i_reg : fish_in.index[AW-1:0];
    assign noise_we   = in_acc && fish_in.kind == KIND_NOISE && idx_ok;

    always_comb
    begin
        if (state_reg == S_WB)
            fish_wdata = '{pos_x: px_reg, pos_y: py_reg, vel_x: nvx_reg, vel_y: nvy_reg,
                           mass: mass_new_reg, fitness: fit_new_reg};
        else
            fish_wdata = '{pos_x: fish_in.pos_x, pos_y: fish_in.pos_y,
                           vel_x: fish_in.vel_x, vel_y: fish_in.vel_y,
                           mass: fish_in.mass, fitness: fish_in.last_fitness};
    end

    always_ff @(posedge clk)
    begin
        if (fish_we)
            fish_mem[fish_waddr] <= fish_wdata;
        if (fish_re)
            fish_rd_reg <= fish_mem[fish_raddr];
        if (noise_we)
            noise_mem[fish_in.index[AW-1:0]] <= '{x: fish_in.noise_x, y: fish_in.noise_y};
        if (noise_re)
            noise_rd_reg <= noise_mem[i_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_vld_reg <= '0;
            noise_hit_reg <= 1'b0;
        end
        else
        begin
            if (noise_we)
                noise_vld_reg[fish_in.index[AW-1:0]] <= 1'b1;
            if (noise_re)
                noise_hit_reg <= noise_vld_reg[i_reg];
        end
    end

    // pair test and pull dividers
    assign dist2     = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign near      = dist2 < {3'b000, r2_reg};
    assign div_start = (state_reg == S_NEAR) && near && (j_reg != i_reg);

    fsi_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numx_reg),
        .den   ({mj_reg, 8'h00}),
        .done  (done_x),
        .quo   (qx)
    );

    fsi_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numy_reg),
        .den   ({mj_reg, 8'h00}),
        .done  (done_y),
        .quo   (qy)
    );

    // arithmetic between registers
    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;
    assign num_x = $signed({1'b0, gain_reg}) * dx_reg;
    assign num_y = $signed({1'b0, gain_reg}) * dy_reg;
    assign px_sq = px_reg * px_reg;
    assign a_sq  = a_reg * a_reg;
    assign t32   = 48'($signed({py_reg, 16'h0000})) - $signed({1'b0, xx_reg});
    assign t32_b = t32[47] ? (t32 + 48'sd65535) : t32;
    assign pk_x  = nvx_reg * $signed({1'b0, keep_reg});
    assign pk_y  = nvy_reg * $signed({1'b0, keep_reg});
    assign pkx_b = pkx_reg[40] ? (pkx_reg + 41'sd65535) : pkx_reg;
    assign pky_b = pky_reg[40] ? (pky_reg + 41'sd65535) : pky_reg;
    assign t_sq  = t16_reg * t16_reg;
    assign fsum  = 48'(a2_reg[47:24]) + 48'(t2_reg) * 48'(CURVE_WEIGHT);
    assign fdiff = $signed({1'b0, fit_new_reg}) - $signed({1'b0, fi_reg});
    assign dn    = fdiff * $signed({1'b0, wgain_reg});
    assign dn_b  = dn_reg[49] ? (dn_reg + 50'sd65535) : dn_reg;
    assign w     = $signed({3'b000, mi_reg}) + 35'(delta_reg);
    assign oob   = (px_reg < blow_reg) || (px_reg > bhigh_reg) ||
                   (py_reg < blow_reg) || (py_reg > bhigh_reg);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_CAPI:
            begin
                pix_reg <= fish_rd_reg.pos_x;
                piy_reg <= fish_rd_reg.pos_y;
                vx_reg  <= fish_rd_reg.vel_x;
                vy_reg  <= fish_rd_reg.vel_y;
                mi_reg  <= fish_rd_reg.mass;
                fi_reg  <= fish_rd_reg.fitness;
                nx_reg  <= noise_hit_reg ? noise_rd_reg.x : '0;
                ny_reg  <= noise_hit_reg ? noise_rd_reg.y : '0;
            end
            S_DIFF:
            begin
                dx_reg <= $signed({fish_rd_reg.pos_x[POS_W-1], fish_rd_reg.pos_x})
                        - $signed({pix_reg[POS_W-1], pix_reg});
                dy_reg <= $signed({fish_rd_reg.pos_y[POS_W-1], fish_rd_reg.pos_y})
                        - $signed({piy_reg[POS_W-1], piy_reg});
                mj_reg <= fish_rd_reg.mass;
            end
            S_MUL:
            begin
                dx2_reg  <= dx_sq[47:0];
                dy2_reg  <= dy_sq[47:0];
                numx_reg <= num_x[NUM_W-1:0];
                numy_reg <= num_y[NUM_W-1:0];
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    vx_reg <= add_pos(vx_reg, qx);
                    vy_reg <= add_pos(vy_reg, qy);
                end
            end
            S_MOVE:
            begin
                px_reg  <= add_pos(pix_reg, vx_reg);
                py_reg  <= add_pos(piy_reg, vy_reg);
                nvx_reg <= add_pos(vx_reg, nx_reg);
                nvy_reg <= add_pos(vy_reg, ny_reg);
            end
            S_F1:
            begin
                if (oob)
                begin
                    nvx_reg <= neg_pos(nvx_reg);
                    nvy_reg <= neg_pos(nvy_reg);
                end
                a_reg  <= $signed(25'd65536) - $signed({px_reg[POS_W-1], px_reg});
                xx_reg <= px_sq[46:0];
            end
            S_F2:
            begin
                a2_reg  <= a_sq[47:0];
                t16_reg <= t32_b[47:16];
                pkx_reg <= pk_x;
                pky_reg <= pk_y;
            end
            S_F3:
            begin
                t2_reg  <= t_sq[63:24];
                nvx_reg <= pkx_b[39:16];
                nvy_reg <= pky_b[39:16];
            end
            S_F4:
            begin
                fit_new_reg <= (fsum[47:32] != '0) ? MASS_MAX : fsum[31:0];
            end
            S_F5:
            begin
                dn_reg <= dn;
            end
            S_F6:
            begin
                delta_reg <= dn_b[49:16];
            end
            S_F7:
            begin
                priority if (w < $signed({3'b000, wfloor_reg}))
                    mass_new_reg <= wfloor_reg;
                else if (w[34:32] != 3'b000)
                    mass_new_reg <= MASS_MAX;
                else
                    mass_new_reg <= w[31:0];
            end
            default: ;
        endcase
    end

    // output register
    logic [INDEX_W-1:0]      o_index_reg;
    fish_t                   o_fish_reg;
    logic                    o_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ECAP && slot_free)
        begin
            o_index_reg <= INDEX_W'(i_reg);
            o_fish_reg  <= fish_rd_reg;
            o_last_reg  <= (i_reg == LAST_SLOT);
        end
    end

    assign fish_out.valid      = out_valid_reg;
    assign fish_out.fish_index = o_index_reg;
    assign fish_out.out_pos_x  = o_fish_reg.pos_x;
    assign fish_out.out_pos_y  = o_fish_reg.pos_y;
    assign fish_out.out_vel_x  = o_fish_reg.vel_x;
    assign fish_out.out_vel_y  = o_fish_reg.vel_y;
    assign fish_out.out_mass   = o_fish_reg.mass;
    assign fish_out.last       = o_last_reg;

    // sequencer: fish i against every j, then update and write back fish i; after the last fish, emit every slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_ECAP && slot_free)
                out_valid_reg <= 1'b1;
            else if (fish_out.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && fish_in.kind == KIND_STEP)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_RDI;
                    end
                end
                S_RDI:  state_reg <= S_CAPI;
                S_CAPI:
                begin
                    j_reg     <= '0;
                    state_reg <= S_RDJ;
                end
                S_RDJ:  state_reg <= S_DIFF;
                S_DIFF: state_reg <= S_MUL;
                S_MUL:  state_reg <= S_NEAR;
                S_NEAR:
                begin
                    priority if (div_start)
                        state_reg <= S_DIV;
                    else if (j_reg == LAST_SLOT)
                        state_reg <= S_MOVE;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RDJ;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (j_reg == LAST_SLOT)
                            state_reg <= S_MOVE;
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_RDJ;
                        end
                    end
                end
                S_MOVE: state_reg <= S_F1;
                S_F1:   state_reg <= S_F2;
                S_F2:   state_reg <= S_F3;
                S_F3:   state_reg <= S_F4;
                S_F4:   state_reg <= S_F5;
                S_F5:   state_reg <= S_F6;
                S_F6:   state_reg <= S_F7;
                S_F7:   state_reg <= S_WB;
                S_WB:
                begin
                    // the next memory read, in S_RDI or S_ERD, follows this write
                    if (i_reg == LAST_SLOT)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RDI;
                    end
                end
                S_ERD:  state_reg <= S_ECAP;
                S_ECAP:
                begin
                    if (slot_free)
                    begin
                        if (i_reg == LAST_SLOT)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/fsi_chk.sv]
// Port-level checks for the fish swarm iteration block, bound to the top level.
module fsi_chk
    import fsi_pkg::*;
#(
    parameter int FISH_COUNT = FISH_COUNT_DEF
)(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [KIND_W-1:0]       in_kind,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [INDEX_W-1:0]      out_index,
    input logic signed [POS_W-1:0] out_pos_x,
    input logic [MASS_W-1:0]       out_mass,
    input logic                    out_last
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) &&
                                    $stable(out_pos_x) && $stable(out_mass))
        else $error("result changed while stalled");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_kind == KIND_STEP |=> !in_ready)
        else $error("item taken while a step runs");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_index == INDEX_W'(FISH_COUNT - 1))
        else $error("last flag on wrong slot");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_kind != KIND_STEP && !out_valid |=> !out_valid)
        else $error("result after load or noise item");

endmodule

bind fish_swarm_iteration_top fsi_chk #(.FISH_COUNT(FISH_COUNT)) u_fsi_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fish_in.valid),
    .in_ready  (fish_in.ready),
    .in_kind   (fish_in.kind),
    .out_valid (fish_out.valid),
    .out_ready (fish_out.ready),
    .out_index (fish_out.fish_index),
    .out_pos_x (fish_out.out_pos_x),
    .out_mass  (fish_out.out_mass),
    .out_last  (fish_out.last)
);
